### rtl/pdt_pkg.sv
// ============================================================================
// pdt_pkg
// Shared types and constants of the prescaled dual timer unit.
// ============================================================================
`default_nettype none

package pdt_pkg;

    // sizing defaults
    localparam int NUM_TIMERS_DEF    = 2;
    localparam int PRESCALE_BITS_DEF = 16;
    localparam int DATA_W            = 32;
    localparam int IDX_W             = 5;
    localparam int IRQ_W             = 2;

    // stream payload widths (fields packed from bit 0, tdata padded to bytes)
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;

    // request kinds
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // global register offsets
    localparam logic [IDX_W-1:0] REG_SCALER     = 5'd0;
    localparam logic [IDX_W-1:0] REG_SCALER_RLD = 5'd1;
    localparam logic [IDX_W-1:0] REG_CONFIG     = 5'd2;

    // per-timer sub offsets
    localparam logic [1:0] SUB_COUNT  = 2'd0;
    localparam logic [1:0] SUB_RELOAD = 2'd1;
    localparam logic [1:0] SUB_CTRL   = 2'd2;

    // control word bits
    localparam int CTL_EN_BIT = 0;
    localparam int CTL_RS_BIT = 1;
    localparam int CTL_LD_BIT = 2;
    localparam int CTL_IE_BIT = 3;
    localparam int CTL_IP_BIT = 4;
    localparam int CTL_CH_BIT = 5;
    localparam int CTL_W      = 6;

    // config word bits
    localparam int CFG_SEP_BIT    = 8;
    localparam int CFG_FREEZE_BIT = 9;

    // write request to one timer cell
    typedef struct packed {
        logic              wr_count;
        logic              wr_reload;
        logic              wr_ctrl;
        logic [DATA_W-1:0] data;
    } t_cell_wr;

    // readable state of one timer cell
    typedef struct packed {
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] reload;
        logic [CTL_W-1:0]  ctrl;
    } t_cell_stat;

endpackage

`default_nettype wire

### rtl/pdt_prescaler.sv
// ============================================================================
// pdt_prescaler
// Shared down-counting prescaler; flags a timer tick when it wraps.
// ============================================================================
`default_nettype none

module pdt_prescaler #(
    parameter int PRESCALE_BITS = pdt_pkg::PRESCALE_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_tick,
    input  wire logic                      i_wr_count,
    input  wire logic                      i_wr_reload,
    input  wire logic [pdt_pkg::DATA_W-1:0] i_data,
    output logic                           o_pre_tick,
    output logic [pdt_pkg::DATA_W-1:0]     o_count,
    output logic [pdt_pkg::DATA_W-1:0]     o_reload
);
    import pdt_pkg::*;

    logic [PRESCALE_BITS-1:0] r_count, n_count;
    logic [PRESCALE_BITS-1:0] r_reload, n_reload;

    // wrap on zero, otherwise count down
    assign o_pre_tick = i_tick && (r_count == '0);

    always_comb begin
        n_count  = r_count;
        n_reload = r_reload;
        if (i_tick) begin
            n_count = (r_count == '0) ? r_reload : r_count - 1'b1;
        end
        if (i_wr_count) begin
            n_count = i_data[PRESCALE_BITS-1:0];
        end
        if (i_wr_reload) begin
            n_reload = i_data[PRESCALE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_reload <= '0;
        end else begin
            r_count  <= n_count;
            r_reload <= n_reload;
        end
    end

    assign o_count  = DATA_W'(r_count);
    assign o_reload = DATA_W'(r_reload);

endmodule

`default_nettype wire

### rtl/pdt_timer_cell.sv
// ============================================================================
// pdt_timer_cell
// One timer of the chain: counter, reload and control flags.
// ============================================================================
`default_nettype none

module pdt_timer_cell #(
    parameter bit IS_FIRST = 1'b0
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_tick,       // unfrozen tick request
    input  wire logic                i_pre_tick,   // prescaler wrap
    input  wire logic                i_prev_under, // neighbor underflow
    input  wire pdt_pkg::t_cell_wr   i_wr,
    output logic                     o_under,
    output logic                     o_pulse,
    output pdt_pkg::t_cell_stat      o_stat
);
    import pdt_pkg::*;

    logic [DATA_W-1:0] r_count, n_count;
    logic [DATA_W-1:0] r_reload, n_reload;
    logic r_en, n_en, r_rs, n_rs, r_ie, n_ie, r_ip, n_ip, r_ch, n_ch;
    logic src, active;

    // first timer has no neighbor and always runs off the prescaler
    assign src     = (!IS_FIRST && r_ch) ? i_prev_under : i_pre_tick;
    assign active  = i_tick && r_en && src;
    assign o_under = active && (r_count == '0);
    assign o_pulse = o_under && r_ie;

    always_comb begin
        n_count  = r_count;
        n_reload = r_reload;
        n_en     = r_en;
        n_rs     = r_rs;
        n_ie     = r_ie;
        n_ip     = r_ip;
        n_ch     = r_ch;
        // counting
        if (active) begin
            if (r_count == '0) begin
                n_ip = 1'b1;
                if (r_rs) begin
                    n_count = r_reload;
                end else begin
                    n_en = 1'b0;
                end
            end else begin
                n_count = r_count - 1'b1;
            end
        end
        // bus writes
        if (i_wr.wr_count) begin
            n_count = i_wr.data;
        end
        if (i_wr.wr_reload) begin
            n_reload = i_wr.data;
        end
        if (i_wr.wr_ctrl) begin
            n_en = i_wr.data[CTL_EN_BIT];
            n_rs = i_wr.data[CTL_RS_BIT];
            n_ie = i_wr.data[CTL_IE_BIT];
            n_ch = i_wr.data[CTL_CH_BIT];
            n_ip = i_wr.data[CTL_IP_BIT] && r_ip;   // write 0 clears
            if (i_wr.data[CTL_LD_BIT]) begin
                n_count = r_reload;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_reload <= '0;
            r_en     <= 1'b0;
            r_rs     <= 1'b0;
            r_ie     <= 1'b0;
            r_ip     <= 1'b0;
            r_ch     <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_reload <= n_reload;
            r_en     <= n_en;
            r_rs     <= n_rs;
            r_ie     <= n_ie;
            r_ip     <= n_ip;
            r_ch     <= n_ch;
        end
    end

    // LD is not stored and reads as zero
    always_comb begin
        o_stat.count                = r_count;
        o_stat.reload               = r_reload;
        o_stat.ctrl                 = '0;
        o_stat.ctrl[CTL_EN_BIT]     = r_en;
        o_stat.ctrl[CTL_RS_BIT]     = r_rs;
        o_stat.ctrl[CTL_IE_BIT]     = r_ie;
        o_stat.ctrl[CTL_IP_BIT]     = r_ip;
        o_stat.ctrl[CTL_CH_BIT]     = r_ch;
    end

endmodule

`default_nettype wire

### rtl/pdt_out_buf.sv
// ============================================================================
// pdt_out_buf
// Output register with a skid stage so requests keep flowing under stall.
// ============================================================================
`default_nettype none

module pdt_out_buf #(
    parameter int W = pdt_pkg::M_TDATA_W
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_ready,
    output logic              o_valid,
    output logic [W-1:0]      o_data,
    input  wire logic         i_pop
);
    logic         r_out_valid, r_skid_valid;
    logic [W-1:0] r_out_data, r_skid_data;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (i_pop) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (i_push) begin
                if (r_out_valid && !i_pop) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_pop) begin
                r_out_data <= r_skid_data;
            end
        end else if (i_push) begin
            if (r_out_valid && !i_pop) begin
                r_skid_data <= i_data;
            end else begin
                r_out_data <= i_data;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/prescaled_dual_timer_unit_core.sv
// ============================================================================
// prescaled_dual_timer_unit_core
// Prescaled timer unit: shared prescaler feeding a chain of timer cells.
// ============================================================================
// Result registered in a two-entry output register/skid before m_tvalid.
// Throughput: one request per cycle while s_tready is high; the prescaler
// and all timer cells update in the accept cycle, underflow ripples down the
// cell chain in that cycle. s_tready drops once the skid entry fills.
// Reset (synchronous, active low): prescaler, config and all timers cleared,
// timers disabled, output buffer empty.
`default_nettype none

module prescaled_dual_timer_unit_core #(
    parameter int NUM_TIMERS    = pdt_pkg::NUM_TIMERS_DEF,
    parameter int PRESCALE_BITS = pdt_pkg::PRESCALE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [4:0] reg_index, [36:5] write_data, [37] debug_halt, [39:38] zero
    input  wire logic [pdt_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] req_type
    input  wire logic [pdt_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [31:0] read_data, [33:32] irq_lines, [34] bad_address, [39:35] zero
    output logic [pdt_pkg::M_TDATA_W-1:0]      m_tdata
);
    import pdt_pkg::*;

    logic              accept;
    logic [1:0]        req_type;
    logic [IDX_W-1:0]  reg_index;
    logic [DATA_W-1:0] write_data;
    logic              debug_halt;
    logic              is_wr, is_rd, is_acc, tick;

    logic              r_freeze, n_freeze;
    logic              r_sep, n_sep;

    logic [2:0]        tsel;
    logic [1:0]        sub;
    logic              is_timer, bad;

    logic              pre_tick;
    logic [DATA_W-1:0] pre_count, pre_reload;
    logic              pre_wr_count, pre_wr_reload;

    t_cell_wr          cell_wr   [NUM_TIMERS];
    t_cell_stat        cell_stat [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] under, pulses;

    logic [DATA_W-1:0] rd_data;
    logic [IRQ_W-1:0]  irq, pulse2;
    logic              buf_ready;

    // request unpacking
    assign accept     = s_tvalid && s_tready;
    assign req_type   = s_tuser[1:0];
    assign reg_index  = s_tdata[IDX_W-1:0];
    assign write_data = s_tdata[IDX_W+DATA_W-1:IDX_W];
    assign debug_halt = s_tdata[IDX_W+DATA_W];

    always_comb begin
        is_wr = 1'b0;
        is_rd = 1'b0;
        unique case (req_type)
            REQ_WRITE: is_wr = accept;
            REQ_READ:  is_rd = accept;
            default:   ;
        endcase
    end
    assign is_acc = is_wr || is_rd;
    assign tick   = accept && (req_type == REQ_TICK) && !(r_freeze && debug_halt);

    // address decode
    assign is_timer = (reg_index[IDX_W-1:2] != '0);
    assign tsel     = reg_index[IDX_W-1:2] - 3'd1;
    assign sub      = reg_index[1:0];
    always_comb begin
        if (is_timer) begin
            bad = ({1'b0, tsel} >= 4'(NUM_TIMERS)) || (sub == 2'd3);
        end else begin
            bad = (reg_index != REG_SCALER) && (reg_index != REG_SCALER_RLD)
               && (reg_index != REG_CONFIG);
        end
    end

    assign pre_wr_count  = is_wr && (reg_index == REG_SCALER);
    assign pre_wr_reload = is_wr && (reg_index == REG_SCALER_RLD);

    // config word
    always_comb begin
        n_freeze = r_freeze;
        n_sep    = r_sep;
        if (is_wr && (reg_index == REG_CONFIG)) begin
            n_freeze = write_data[CFG_FREEZE_BIT];
            n_sep    = write_data[CFG_SEP_BIT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freeze <= 1'b0;
            r_sep    <= 1'b0;
        end else begin
            r_freeze <= n_freeze;
            r_sep    <= n_sep;
        end
    end

    pdt_prescaler #(
        .PRESCALE_BITS (PRESCALE_BITS)
    ) u_prescaler (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (tick),
        .i_wr_count  (pre_wr_count),
        .i_wr_reload (pre_wr_reload),
        .i_data      (write_data),
        .o_pre_tick  (pre_tick),
        .o_count     (pre_count),
        .o_reload    (pre_reload)
    );

    // chain of timer cells
    for (genvar gi = 0; gi < NUM_TIMERS; gi++) begin : g_cell
        logic sel, prev;

        assign sel = is_wr && is_timer && (tsel == 3'(gi));
        assign cell_wr[gi].wr_count  = sel && (sub == SUB_COUNT);
        assign cell_wr[gi].wr_reload = sel && (sub == SUB_RELOAD);
        assign cell_wr[gi].wr_ctrl   = sel && (sub == SUB_CTRL);
        assign cell_wr[gi].data      = write_data;

        if (gi == 0) begin : g_head
            assign prev = 1'b0;
        end else begin : g_link
            assign prev = under[gi-1];
        end

        pdt_timer_cell #(
            .IS_FIRST (gi == 0)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_tick       (tick),
            .i_pre_tick   (pre_tick),
            .i_prev_under (prev),
            .i_wr         (cell_wr[gi]),
            .o_under      (under[gi]),
            .o_pulse      (pulses[gi]),
            .o_stat       (cell_stat[gi])
        );
    end

    // read mux
    always_comb begin
        rd_data = '0;
        if (is_rd && !bad) begin
            if (is_timer) begin
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (tsel == 3'(i)) begin
                        unique case (sub)
                            SUB_COUNT:  rd_data = cell_stat[i].count;
                            SUB_RELOAD: rd_data = cell_stat[i].reload;
                            SUB_CTRL:   rd_data = DATA_W'(cell_stat[i].ctrl);
                            default:    rd_data = '0;
                        endcase
                    end
                end
            end else if (reg_index == REG_SCALER) begin
                rd_data = pre_count;
            end else if (reg_index == REG_SCALER_RLD) begin
                rd_data = pre_reload;
            end else begin
                rd_data[CFG_FREEZE_BIT] = r_freeze;
                rd_data[CFG_SEP_BIT]    = r_sep;
            end
        end
    end

    // interrupt routing: per timer or all on line 0
    assign pulse2 = IRQ_W'(pulses);
    always_comb begin
        irq = '0;
        if (r_sep) begin
            irq = pulse2;
        end else begin
            irq[0] = |pulses;
        end
    end

    pdt_out_buf #(
        .W (M_TDATA_W)
    ) u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  ({5'd0, is_acc && bad, irq, rd_data}),
        .o_ready (buf_ready),
        .o_valid (m_tvalid),
        .o_data  (m_tdata),
        .i_pop   (m_tready)
    );

    assign s_tready = buf_ready;

endmodule

`default_nettype wire

### sim/pdt_checker.sv
// ============================================================================
// pdt_checker
// Watches the request and response channels of the timer unit, keeps its own copy of the
// prescaler and timer state, predicts the response of each accepted request
// and compares every response field against the oldest prediction.
// ============================================================================

module pdt_checker
    import pdt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [S_TUSER_W-1:0] i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int               NT         = NUM_TIMERS_DEF;
    localparam int               PB         = PRESCALE_BITS_DEF;
    localparam logic [IDX_W-1:0] TIMER_BASE = 5'd4;
    localparam int               MAX_PRINTS = 40;

    typedef struct packed {
        logic ch;
        logic ip;
        logic ie;
        logic rs;
        logic en;
    } t_flags;

    typedef struct packed {
        logic [DATA_W-1:0] rd;
        logic [IRQ_W-1:0]  irq;
        logic              bad;
    } t_response;

    // shadow copy of the unit's state
    logic [PB-1:0]     scaler_cnt;
    logic [PB-1:0]     scaler_rld;
    logic              freeze_en;
    logic              sep_irqs;
    logic [DATA_W-1:0] tmr_count  [NT];
    logic [DATA_W-1:0] tmr_reload [NT];
    t_flags            tmr_flags  [NT];

    t_response         response_q [$];

    // one tick: prescaler step, then timers in order so chains ripple
    function automatic logic [IRQ_W-1:0] timer_tick(input logic halt);
        logic          scaler_tick;
        logic          prev_under;
        logic          src;
        logic          under;
        logic [NT-1:0] pulses;
        scaler_tick = 1'b0;
        prev_under  = 1'b0;
        pulses      = '0;
        if (!(freeze_en && halt)) begin
            if (scaler_cnt == '0) begin
                scaler_cnt  = scaler_rld;
                scaler_tick = 1'b1;
            end else begin
                scaler_cnt = scaler_cnt - 1'b1;
            end
            for (int i = 0; i < NT; i++) begin
                src   = (i > 0 && tmr_flags[i].ch) ? prev_under : scaler_tick;
                under = 1'b0;
                if (tmr_flags[i].en && src) begin
                    if (tmr_count[i] == '0) begin
                        under           = 1'b1;
                        tmr_flags[i].ip = 1'b1;
                        if (tmr_flags[i].ie) pulses[i] = 1'b1;
                        if (tmr_flags[i].rs) tmr_count[i] = tmr_reload[i];
                        else tmr_flags[i].en = 1'b0;
                    end else begin
                        tmr_count[i] = tmr_count[i] - 1'b1;
                    end
                end
                prev_under = under;
            end
        end
        return sep_irqs ? IRQ_W'(pulses) : IRQ_W'(|pulses);
    endfunction

    // apply one request to the shadow state and build its response
    task automatic apply_request(input logic [1:0] kind, input logic [IDX_W-1:0] idx,
                                 input logic [DATA_W-1:0] data, input logic halt,
                                 output t_response res);
        logic             wr;
        logic [IDX_W-1:0] slot;
        int unsigned      tsel;
        res  = '0;
        wr   = (kind == REQ_WRITE);
        slot = idx - TIMER_BASE;
        tsel = slot >> 2;
        if (kind == REQ_TICK) begin
            res.irq = timer_tick(halt);
        end else if (kind == REQ_WRITE || kind == REQ_READ) begin
            if (idx < TIMER_BASE) begin
                case (idx)
                    REG_SCALER: begin
                        if (wr) scaler_cnt = data[PB-1:0];
                        else res.rd = DATA_W'(scaler_cnt);
                    end
                    REG_SCALER_RLD: begin
                        if (wr) scaler_rld = data[PB-1:0];
                        else res.rd = DATA_W'(scaler_rld);
                    end
                    REG_CONFIG: begin
                        if (wr) begin
                            freeze_en = data[CFG_FREEZE_BIT];
                            sep_irqs  = data[CFG_SEP_BIT];
                        end else begin
                            res.rd[CFG_FREEZE_BIT] = freeze_en;
                            res.rd[CFG_SEP_BIT]    = sep_irqs;
                        end
                    end
                    default: res.bad = 1'b1;
                endcase
            end else if (tsel >= NT) begin
                res.bad = 1'b1;
            end else begin
                case (slot[1:0])
                    SUB_COUNT: begin
                        if (wr) tmr_count[tsel] = data;
                        else res.rd = tmr_count[tsel];
                    end
                    SUB_RELOAD: begin
                        if (wr) tmr_reload[tsel] = data;
                        else res.rd = tmr_reload[tsel];
                    end
                    SUB_CTRL: begin
                        if (wr) begin
                            // IP can only be cleared by software, never set
                            tmr_flags[tsel].en = data[CTL_EN_BIT];
                            tmr_flags[tsel].rs = data[CTL_RS_BIT];
                            tmr_flags[tsel].ie = data[CTL_IE_BIT];
                            tmr_flags[tsel].ch = data[CTL_CH_BIT];
                            tmr_flags[tsel].ip = data[CTL_IP_BIT] & tmr_flags[tsel].ip;
                            if (data[CTL_LD_BIT]) tmr_count[tsel] = tmr_reload[tsel];
                        end else begin
                            res.rd[CTL_EN_BIT] = tmr_flags[tsel].en;
                            res.rd[CTL_RS_BIT] = tmr_flags[tsel].rs;
                            res.rd[CTL_IE_BIT] = tmr_flags[tsel].ie;
                            res.rd[CTL_IP_BIT] = tmr_flags[tsel].ip;
                            res.rd[CTL_CH_BIT] = tmr_flags[tsel].ch;
                        end
                    end
                    default: res.bad = 1'b1;
                endcase
            end
        end
    endtask

    task automatic report(input string what, input logic [DATA_W-1:0] want,
                          input logic [DATA_W-1:0] got);
        if (o_fail_count < MAX_PRINTS)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        o_fail_count++;
    endtask

    // responses are compared before the new request is predicted, so an
    // extra response can never match a prediction made in the same cycle
    always @(posedge i_clk) begin : monitor
        t_response got;
        t_response want;
        t_response next;
        if (!i_rst_n) begin
            scaler_cnt = '0;
            scaler_rld = '0;
            freeze_en  = 1'b0;
            sep_irqs   = 1'b0;
            for (int i = 0; i < NT; i++) begin
                tmr_count[i]  = '0;
                tmr_reload[i] = '0;
                tmr_flags[i]  = '0;
            end
            response_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.rd  = i_m_tdata[DATA_W-1:0];
                got.irq = i_m_tdata[DATA_W +: IRQ_W];
                got.bad = i_m_tdata[DATA_W + IRQ_W];
                if (response_q.size() == 0) begin
                    report("unexpected response", '0, DATA_W'(got));
                end else begin
                    want = response_q.pop_front();
                    if (got.rd !== want.rd) report("read_data", want.rd, got.rd);
                    if (got.irq !== want.irq)
                        report("irq_lines", DATA_W'(want.irq), DATA_W'(got.irq));
                    if (got.bad !== want.bad)
                        report("bad_address", DATA_W'(want.bad), DATA_W'(got.bad));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_request(i_s_tuser, i_s_tdata[IDX_W-1:0],
                              i_s_tdata[IDX_W +: DATA_W], i_s_tdata[IDX_W + DATA_W], next);
                response_q.push_back(next);
            end
        end
        o_pending = response_q.size();
    end

endmodule

### sim/testbench.sv
// ============================================================================
// testbench
// Drives register accesses and tick requests into the timer unit: a short
// directed sequence (freeze, chaining, unmapped offsets, wide writes) and a
// long random mix with random idling on both channels. The checker predicts
// and compares every response; this module gives the verdict.
// ============================================================================

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pdt_pkg::*;

    localparam int               NT            = NUM_TIMERS_DEF;
    localparam int               RANDOM_ITEMS  = 1825;
    localparam int               STALL_LIMIT   = 1000;
    localparam logic [1:0]       REQ_NONE      = 2'd3;
    localparam logic [IDX_W-1:0] REG_GAP       = 5'd3;
    localparam logic [1:0]       SUB_HOLE      = 2'd3;
    localparam logic [DATA_W-1:0] M_EN         = DATA_W'(1) << CTL_EN_BIT;
    localparam logic [DATA_W-1:0] M_RS         = DATA_W'(1) << CTL_RS_BIT;
    localparam logic [DATA_W-1:0] M_LD         = DATA_W'(1) << CTL_LD_BIT;
    localparam logic [DATA_W-1:0] M_IE         = DATA_W'(1) << CTL_IE_BIT;
    localparam logic [DATA_W-1:0] M_IP         = DATA_W'(1) << CTL_IP_BIT;
    localparam logic [DATA_W-1:0] M_CH         = DATA_W'(1) << CTL_CH_BIT;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [4:0] reg_index, [36:5] write_data, [37] debug_halt
    logic [S_TUSER_W-1:0] s_tuser  = '0;   // [1:0] req_type
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [31:0] read_data, [33:32] irq_lines, [34] bad_address

    int                   fail_count;
    int                   pending;
    int                   quiet_cycles = 0;
    logic                 steady = 1'b0;   // no idling on either side while set

    prescaled_dual_timer_unit_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    pdt_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // response side backpressure
    always @(negedge i_clk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 20);
    end

    // watchdog: ends the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [IDX_W-1:0] timer_reg(input int unsigned t, input logic [1:0] sub);
        return IDX_W'(4 + 4 * t + sub);
    endfunction

    // mostly mapped offsets, some anywhere in the index range
    function automatic logic [IDX_W-1:0] pick_index();
        if ($urandom_range(0, 99) < 20) return IDX_W'($urandom_range(0, 31));
        if ($urandom_range(0, 2) == 0) return IDX_W'($urandom_range(REG_SCALER, REG_CONFIG));
        return timer_reg($urandom_range(0, NT - 1), 2'($urandom_range(SUB_COUNT, SUB_CTRL)));
    endfunction

    // called and returns at a falling edge; holds the request until accepted
    task automatic send_req(input logic [1:0] kind, input logic [IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] data, input logic halt);
        if (!steady) begin
            while ($urandom_range(0, 99) < 20) begin
                s_tvalid <= 1'b0;
                @(negedge i_clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'({halt, data, idx});
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int unsigned      roll;
        logic [1:0]       kind;
        logic [IDX_W-1:0] idx;
        logic [DATA_W-1:0] data;
        logic             halt;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset values, config bits, wide prescaler write
        send_req(REQ_READ,  REG_CONFIG, '0, 1'b0);
        send_req(REQ_WRITE, REG_CONFIG, '1, 1'b1);
        send_req(REQ_READ,  REG_CONFIG, '0, 1'b0);
        send_req(REQ_WRITE, REG_SCALER, '1, 1'b0);
        send_req(REQ_READ,  REG_SCALER, '0, 1'b0);
        send_req(REQ_WRITE, REG_SCALER, '0, 1'b0);
        send_req(REQ_WRITE, REG_SCALER_RLD, 32'd1, 1'b0);
        // timer 0 auto-reloads with CH set (ignored on the first timer),
        // timer 1 chained one-shot
        send_req(REQ_WRITE, timer_reg(0, SUB_RELOAD), 32'd2, 1'b0);
        send_req(REQ_WRITE, timer_reg(0, SUB_CTRL), M_EN | M_RS | M_LD | M_IE | M_IP | M_CH,
                 1'b0);
        send_req(REQ_WRITE, timer_reg(1, SUB_RELOAD), '0, 1'b0);
        send_req(REQ_WRITE, timer_reg(1, SUB_CTRL), M_EN | M_IE | M_CH, 1'b0);
        // frozen tick, then enough ticks for both timers to underflow together
        send_req(REQ_TICK, '0, '0, 1'b1);
        repeat (6) send_req(REQ_TICK, '0, '0, 1'b0);
        send_req(REQ_READ,  timer_reg(0, SUB_CTRL), '0, 1'b0);
        send_req(REQ_WRITE, timer_reg(0, SUB_CTRL), M_EN | M_RS | M_IE, 1'b0);
        // unmapped offsets and the unused request kind
        send_req(REQ_READ,  REG_GAP, '0, 1'b0);
        send_req(REQ_WRITE, timer_reg(0, SUB_HOLE), '1, 1'b0);
        send_req(REQ_READ,  timer_reg(6, SUB_HOLE), '0, 1'b0);
        send_req(REQ_READ,  timer_reg(NT, SUB_COUNT), '0, 1'b0);
        send_req(REQ_NONE,  '1, '1, 1'b1);

        // random mix, ticks dominate so the timers keep underflowing
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 700 && n < 1100);
            roll   = $urandom_range(0, 99);
            halt   = 1'($urandom_range(0, 1));
            data   = $urandom();
            idx    = pick_index();
            if (roll < 55) begin
                kind = REQ_TICK;
                halt = ($urandom_range(0, 9) == 0);
            end else if (roll < 75) begin
                kind = REQ_WRITE;
                if (idx == REG_SCALER || idx == REG_SCALER_RLD) begin
                    if ($urandom_range(0, 7) != 0) data = $urandom_range(0, 3);
                end else if (idx >= timer_reg(0, SUB_COUNT) && idx[1:0] == SUB_CTRL) begin
                    if ($urandom_range(0, 99) < 75) data = data | M_EN;
                end else if (idx >= timer_reg(0, SUB_COUNT)) begin
                    if ($urandom_range(0, 3) != 0) data = $urandom_range(0, 7);
                end
            end else if (roll < 93) begin
                kind = REQ_READ;
            end else begin
                kind = 2'($urandom_range(0, 3));
                idx  = IDX_W'($urandom_range(0, 31));
            end
            send_req(kind, idx, data, halt);
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
